/* rtl/core/spq_pkg.sv */
package spq_pkg;

    localparam int QueueDepthDefault = 16;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        STATUS_DONE   = 2'd0,
        STATUS_FULL   = 2'd1,
        STATUS_EMPTY  = 2'd2
    } status_t;

    typedef struct packed {
        logic [3:0] level;
        logic [1:0] role;
    } entry_t;

    typedef struct packed {
        logic   occ;
        entry_t entry;
    } slot_t;

    // Broadcast to every cell for the current beat.
    typedef struct packed {
        logic   en;
        logic   insert;
        entry_t entry;
    } cell_cmd_t;

    typedef struct packed {
        logic       func;
        logic [3:0] key_level;
        logic [1:0] tag_role;
    } req_t;

    typedef struct packed {
        logic       head_valid;
        logic [3:0] head_level;
        logic [1:0] head_role;
        logic [4:0] entry_count;
        logic [1:0] status;
    } rsp_t;

endpackage

/* rtl/core/spq_cell.sv */
module spq_cell
    import spq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cell_cmd_t cmd,
    input  slot_t     left,
    input  logic      left_cond,
    input  slot_t     right,
    output slot_t     slot,
    output logic      cond,
    output slot_t     slot_next
);

    logic   occ_reg;
    entry_t entry_reg;

    // Insert point is at or after this cell: free slot, or key not below the new one.
    assign cond = !occ_reg || (entry_reg.level >= cmd.entry.level);

    always_comb
    begin
        slot_next.occ   = occ_reg;
        slot_next.entry = entry_reg;
        if (cmd.en) begin
            if (cmd.insert) begin
                slot_next.occ = left.occ;
                if (left_cond) begin
                    slot_next.entry = left.entry;
                end else if (cond) begin
                    slot_next.entry = cmd.entry;
                end
            end else begin
                slot_next = right;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            occ_reg <= 1'b0;
        end else begin
            occ_reg <= slot_next.occ;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= slot_next.entry;
    end

    assign slot.occ   = occ_reg;
    assign slot.entry = entry_reg;

endmodule

/* rtl/core/sorted_insert_priority_queue_unit.sv */
// Channel  Direction  Payload  Handshake
// req      in         req_t    req_valid / req_stall (driven here)
// rsp      out        rsp_t    rsp_valid / rsp_stall (driven by sink)
//
// One request beat per cycle while req_stall is low; its response appears in the cycle after acceptance.
// Each cell compares its key with the new one and shifts with its neighbor in
// the same cycle, so an operation's time does not grow with depth.
// req_stall is high only while a response is held and rsp_stall is high.
// Reset clears all occupied flags, the count and the response valid.
module sorted_insert_priority_queue_unit
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QueueDepthDefault
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic           accept;
    logic           full;
    logic           empty;
    cell_cmd_t      cmd;
    slot_t          slots     [QUEUE_DEPTH];
    slot_t          slots_nxt [QUEUE_DEPTH];
    logic           conds     [QUEUE_DEPTH];
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;
    logic [31:0]    count_wide;
    status_t        status;
    logic           rsp_valid_reg;
    rsp_t           rsp_reg;
    rsp_t           rsp_next;

    // Accept whenever the output register is free or being drained this cycle.
    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;

    // Chain ends tell full/empty directly.
    assign full  = slots[QUEUE_DEPTH-1].occ;
    assign empty = !slots[0].occ;

    always_comb
    begin
        cmd.insert      = (req.func == FUNC_INSERT);
        cmd.entry.level = req.key_level;
        cmd.entry.role  = req.tag_role;
        cmd.en          = 1'b0;
        status          = STATUS_DONE;
        count_next      = count_reg;
        if (accept) begin
            if (req.func == FUNC_INSERT) begin
                if (full) begin
                    status = STATUS_FULL;
                end else begin
                    cmd.en     = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end else begin
                if (empty) begin
                    status = STATUS_EMPTY;
                end else begin
                    cmd.en     = 1'b1;
                    count_next = count_reg - 1'b1;
                end
            end
        end
    end

    // Cell row: slot 0 is the head. Insert shifts toward the tail, remove toward the head.
    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        slot_t left_slot;
        logic  left_cond;
        slot_t right_slot;

        if (i == 0) begin : g_head
            // Head always becomes occupied on insert; never takes from the left.
            assign left_slot.occ   = 1'b1;
            assign left_slot.entry = cmd.entry;
            assign left_cond       = 1'b0;
        end else begin : g_mid
            assign left_slot = slots[i-1];
            assign left_cond = conds[i-1];
        end

        if (i == QUEUE_DEPTH - 1) begin : g_tail
            assign right_slot.occ   = 1'b0;
            assign right_slot.entry = slots[i].entry;
        end else begin : g_body
            assign right_slot = slots[i+1];
        end

        spq_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd),
            .left      (left_slot),
            .left_cond (left_cond),
            .right     (right_slot),
            .slot      (slots[i]),
            .cond      (conds[i]),
            .slot_next (slots_nxt[i])
        );
    end

    // Count shown modulo 32.
    assign count_wide = {{(32-CW){1'b0}}, count_next};

    always_comb
    begin
        rsp_next.head_valid  = slots_nxt[0].occ;
        rsp_next.head_level  = slots_nxt[0].occ ? slots_nxt[0].entry.level : 4'd0;
        rsp_next.head_role   = slots_nxt[0].occ ? slots_nxt[0].entry.role  : 2'd0;
        rsp_next.entry_count = count_wide[4:0];
        rsp_next.status      = status;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (accept) begin
                rsp_valid_reg <= 1'b1;
            end else if (!rsp_stall) begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
